// ----- rtl/ouwl_pkg.sv -----
// Package for the ordered unique waiter list.
// Opcode and status codes, cell command struct. No dependencies.
package ouwl_pkg;

  localparam int unsigned IdW    = 16;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_DONE   = 3'd0,
    ST_DUP    = 3'd1,
    ST_FULL   = 3'd2,
    ST_ABSENT = 3'd3,
    ST_ZERO   = 3'd4
  } status_e;

  typedef struct packed {
    logic             remove;
    logic             append;
    logic [IdW-1:0]   key;
  } cell_cmd_t;

endpackage

// ----- rtl/ouwl_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on ouwl_pkg for field widths.
interface ouwl_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic [ouwl_pkg::IdW-1:0]  waiter_id;

  modport source (output valid, output opcode, output waiter_id, input ready);
  modport sink   (input valid, input opcode, input waiter_id, output ready);
endinterface

interface ouwl_out_if;
  logic                         valid;
  logic                         ready;
  logic [ouwl_pkg::IdW-1:0]     result_id;
  logic [2:0]                   status;
  logic [ouwl_pkg::CountW-1:0]  entry_count;

  modport source (output valid, output result_id, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input result_id, input status, input entry_count,
                  output ready);
endinterface

// ----- rtl/ordered_unique_waiter_list_core.sv -----
// Ordered unique waiter list: a row of DEPTH cells holding nonzero IDs, oldest in cell 0.
// Each request is first captured into the opcode and key registers; then every cell compares
// its ID against the key, the match is encoded and the row compacts or appends at the edge;
// the result then sits in an output register. A stalled output holds the compare step until
// the register frees. Cells reset to empty at once; no clearing pass. Uses ouwl_pkg, ouwl_if.
module ordered_unique_waiter_list_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ouwl_in_if.sink       in_i,
  ouwl_out_if.source    out_o
);

  localparam int unsigned PosW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OccW = $clog2(DEPTH + 1);

  logic                        busy_q;
  logic [1:0]                  op_q;
  logic [ouwl_pkg::IdW-1:0]    key_q;
  logic [OccW-1:0]             occ_q, occ_d;

  logic                        out_valid_q;
  logic [ouwl_pkg::IdW-1:0]    res_q, res_d;
  ouwl_pkg::status_e           status_q, status_d;

  logic [ouwl_pkg::IdW-1:0]    cell_id [DEPTH];
  logic [DEPTH-1:0]            match;
  logic [PosW-1:0]             enc_pos, pos;
  logic                        hit;
  logic                        fire;
  logic                        do_remove, do_append;
  ouwl_pkg::cell_cmd_t         cmd;
  logic [OccW+ouwl_pkg::CountW-1:0] occ_ext;

  assign in_i.ready = !busy_q;
  assign fire       = busy_q && (!out_valid_q || out_o.ready);

  ouwl_enc #(.N(DEPTH), .PosW(PosW)) u_enc (
    .match_i (match),
    .pos_o   (enc_pos),
    .hit_o   (hit)
  );

  always_comb begin
    res_d     = '0;
    status_d  = ouwl_pkg::ST_DONE;
    pos       = enc_pos;
    do_remove = 1'b0;
    do_append = 1'b0;
    occ_d     = occ_q;
    unique case (ouwl_pkg::opcode_e'(op_q)) inside
      ouwl_pkg::OP_PUSH: begin
        if (key_q == '0) begin
          status_d = ouwl_pkg::ST_ZERO;
        end else if (hit) begin
          status_d = ouwl_pkg::ST_DUP;
        end else if (occ_q == OccW'(DEPTH)) begin
          status_d = ouwl_pkg::ST_FULL;
        end else begin
          do_append = 1'b1;
          occ_d     = occ_q + OccW'(1);
        end
      end
      ouwl_pkg::OP_POP, ouwl_pkg::OP_PEEK: begin
        if (occ_q == '0) begin
          status_d = ouwl_pkg::ST_ABSENT;
        end else if (key_q == '0) begin
          pos   = '0;
          res_d = cell_id[0];
        end else if (!hit) begin
          status_d = ouwl_pkg::ST_ABSENT;
        end else begin
          res_d = key_q;
        end
        if ((status_d == ouwl_pkg::ST_DONE) && (op_q == ouwl_pkg::OP_POP)) begin
          do_remove = 1'b1;
          occ_d     = occ_q - OccW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign cmd.remove = fire && do_remove;
  assign cmd.append = fire && do_append;
  assign cmd.key    = key_q;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ouwl_pkg::IdW-1:0] next_id;
    if (g == DEPTH - 1) begin : g_last
      assign next_id = '0;
    end else begin : g_mid
      assign next_id = cell_id[g+1];
    end
    ouwl_cell #(.Idx(g), .PosW(PosW)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .pos_i     (pos),
      .tail_i    (occ_q[PosW-1:0]),
      .next_id_i (next_id),
      .id_o      (cell_id[g]),
      .match_o   (match[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        busy_q <= 1'b1;
      end else if (fire) begin
        busy_q <= 1'b0;
      end
      if (fire) begin
        occ_q       <= occ_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q  <= in_i.opcode;
      key_q <= in_i.waiter_id;
    end
    if (fire) begin
      res_q    <= res_d;
      status_q <= status_d;
    end
  end

  // entry count carries the low bits of the occupancy after the update
  assign occ_ext = (OccW + ouwl_pkg::CountW)'(occ_q);

  assign out_o.valid       = out_valid_q;
  assign out_o.result_id   = res_q;
  assign out_o.status      = status_q;
  assign out_o.entry_count = occ_ext[ouwl_pkg::CountW-1:0];

endmodule

// ----- rtl/ouwl_cell.sv -----
// One slot of the waiter list: holds an ID, compares it against the key,
// shifts in its younger neighbour on removal, loads the key on append. Uses ouwl_pkg.
module ouwl_cell #(
  parameter int unsigned Idx = 0,
  parameter int unsigned PosW = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ouwl_pkg::cell_cmd_t        cmd_i,
  input  logic [PosW-1:0]            pos_i,
  input  logic [PosW-1:0]            tail_i,
  input  logic [ouwl_pkg::IdW-1:0]   next_id_i,
  output logic [ouwl_pkg::IdW-1:0]   id_o,
  output logic                       match_o
);

  logic [ouwl_pkg::IdW-1:0] id_q, id_d;

  assign match_o = (id_q == cmd_i.key) && (id_q != '0);
  assign id_o    = id_q;

  always_comb begin
    id_d = id_q;
    if (cmd_i.remove && (pos_i <= PosW'(Idx))) begin
      id_d = next_id_i;
    end else if (cmd_i.append && (tail_i == PosW'(Idx))) begin
      id_d = cmd_i.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q <= '0;
    end else begin
      id_q <= id_d;
    end
  end

endmodule

// ----- rtl/ouwl_enc.sv -----
// One-hot to binary encoder over the cell match lines.
// Standalone; no package use.
module ouwl_enc #(
  parameter int unsigned N = 16,
  parameter int unsigned PosW = 4
) (
  input  logic [N-1:0]     match_i,
  output logic [PosW-1:0]  pos_o,
  output logic             hit_o
);

  always_comb begin
    pos_o = '0;
    for (int unsigned i = 0; i < N; i++) begin
      pos_o = pos_o | (match_i[i] ? PosW'(i) : '0);
    end
  end

  assign hit_o = |match_i;

endmodule

// ----- rtl/ouwl_checker.sv -----
// Port-level checks for the waiter list core, attached by bind.
// Depends on ouwl_pkg and ordered_unique_waiter_list_core.
module ouwl_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [ouwl_pkg::IdW-1:0]      result_id_i,
  input logic [2:0]                    status_i,
  input logic [ouwl_pkg::CountW-1:0]   entry_count_i
);

  localparam logic [DEPTH+ouwl_pkg::CountW-1:0] DepthExt =
    (DEPTH + ouwl_pkg::CountW)'(DEPTH);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_id_i)
      && $stable(status_i) && $stable(entry_count_i))
    else $error("result changed while stalled");

  // one request in flight at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ouwl_pkg::ST_FULL)
      |-> entry_count_i == DepthExt[ouwl_pkg::CountW-1:0])
    else $error("full reported below capacity");

  a_fail_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ouwl_pkg::ST_DONE) |-> result_id_i == '0)
    else $error("ID returned on a failed transfer");

endmodule

bind ordered_unique_waiter_list_core ouwl_checker #(.DEPTH(DEPTH)) u_ouwl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .result_id_i   (out_o.result_id),
  .status_i      (out_o.status),
  .entry_count_i (out_o.entry_count)
);
